FILE: sv/covariate_greedy_match_defines.svh
// Assertion macros for the covariate matcher checker.
// Depends on nothing; included by the checker file only.
`ifndef COVARIATE_GREEDY_MATCH_DEFINES_SVH
`define COVARIATE_GREEDY_MATCH_DEFINES_SVH

// Implication in the same cycle, disabled during reset.
`define CGM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("covariate matcher check failed");

// Implication in the next cycle, disabled during reset.
`define CGM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("covariate matcher check failed");

`endif

FILE: sv/cgm_pkg.sv
// Shared types, codes and constants of the covariate matcher.
// Depends on nothing; used by every module of the block.
package cgm_pkg;

   localparam int VAL_W     = 32;
   localparam int THR_W     = 31;
   localparam int NUM_THR   = 6;
   localparam int CIRC_W    = 6;
   localparam int NCOL_W    = 3;
   localparam int ROW_OUT_W = 11;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 31;

   localparam int DEF_MAX_ROWS = 1024;
   localparam int DEF_MAX_COLS = 6;

   // Score, divider and ratio widths.
   localparam int DIFF_W = 35;
   localparam int SC_W   = 51;
   localparam int DVD_W  = 66;
   localparam int DVS_W  = 32;
   localparam int RAT_W  = 64;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_MATCH  = 2'd2;

   localparam logic [STAT_W-1:0] ST_MATCHED = 2'd0;
   localparam logic [STAT_W-1:0] ST_NONE    = 2'd1;
   localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_THRES_LAST  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CIRC_MASK   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 3'd7;

   localparam logic [THR_W-1:0]  THR_RESET  = 31'd65536;
   localparam logic [NCOL_W-1:0] COLS_RESET = 3'd6;

   localparam logic signed [DIFF_W-1:0] DEG180 = 35'sd11796480;
   localparam logic signed [DIFF_W-1:0] DEG360 = 35'sd23592960;
   localparam logic signed [SC_W-1:0]   SCORE_SAT = 51'sd281474976710655;
   localparam logic [DVD_W-1:0]         RATIO_LIM = 66'h4000_0000_0000_0000;
   localparam logic signed [RAT_W-1:0]  RATIO_SAT = 64'sh4000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]              req_type;
      logic signed [VAL_W-1:0] val_0;
      logic signed [VAL_W-1:0] val_1;
      logic signed [VAL_W-1:0] val_2;
      logic signed [VAL_W-1:0] val_3;
      logic signed [VAL_W-1:0] val_4;
      logic signed [VAL_W-1:0] val_5;
   } cgm_req_type;

   typedef struct packed {
      logic [ROW_OUT_W-1:0] match_row;
      logic [STAT_W-1:0]    status;
   } cgm_rsp_type;

   typedef struct packed {
      logic clear;
      logic append;
      logic drop;
      logic start;
      logic rd_row;
      logic row_adv;
      logic col_zero;
      logic col_adv;
      logic score_direct;
      logic sdiv_start;
      logic score_div;
      logic rdiv_start;
      logic ratio_ld;
      logic row_end;
      logic finish;
   } cgm_cmd_type;

   typedef struct packed {
      logic full;
      logic row_done;
      logic live;
      logic circ_div;
      logic below_thr;
      logic thr_zero;
      logic col_last;
      logic div_done;
      logic out_free;
   } cgm_stat_type;

endpackage

FILE: sv/cgm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cgm_pkg for the operand widths.
module cgm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cgm_pkg::DVD_W-1:0]    dividend,
   input  logic [cgm_pkg::DVS_W-1:0]    divisor,
   output logic                         done,
   output logic [cgm_pkg::DVD_W-1:0]    quotient
);
   localparam int DVD_W = cgm_pkg::DVD_W;
   localparam int DVS_W = cgm_pkg::DVS_W;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!diff[DVS_W]) begin
            rem_in = diff[DVS_W-1:0];
         end else begin
            rem_in = shifted[DVS_W-1:0];
         end
         quo_in = {quo_ff[DVD_W-2:0], ~diff[DVS_W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: sv/cgm_datapath.sv
// Datapath of the covariate matcher: registers, candidate memories, scoring,
// ratio tracking and the result register. Depends on cgm_pkg and cgm_div.
module cgm_datapath #(
   parameter int MAX_ROWS = cgm_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = cgm_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [cgm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cgm_pkg::CSR_W-1:0]       csr_wdata,
   input  cgm_pkg::cgm_req_type            req_data,
   input  cgm_pkg::cgm_cmd_type            cmd,
   output cgm_pkg::cgm_stat_type           stat,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cgm_pkg::cgm_rsp_type            rsp_data
);
   localparam int VAL_W  = cgm_pkg::VAL_W;
   localparam int THR_W  = cgm_pkg::THR_W;
   localparam int DIFF_W = cgm_pkg::DIFF_W;
   localparam int SC_W   = cgm_pkg::SC_W;
   localparam int DVD_W  = cgm_pkg::DVD_W;
   localparam int DVS_W  = cgm_pkg::DVS_W;
   localparam int RAT_W  = cgm_pkg::RAT_W;
   localparam int NCOL_W = cgm_pkg::NCOL_W;
   localparam int OUT_W  = cgm_pkg::ROW_OUT_W;
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   typedef logic [MAX_COLS-1:0][VAL_W-1:0] row_word_type;

   // Configuration registers.
   logic [THR_W-1:0]          thr_ff [cgm_pkg::NUM_THR];
   logic [cgm_pkg::CIRC_W-1:0] circ_ff;
   logic [NCOL_W-1:0]         ncfg_ff;

   // Candidate storage.
   row_word_type cand_mem [MAX_ROWS];
   logic         live_mem [MAX_ROWS];
   row_word_type rd_row_ff;
   logic         rd_live_ff;

   logic [RW:0]               rows_ff;
   logic [RW:0]               row_ff;
   logic [CW-1:0]             col_ff;
   logic [NCOL_W-1:0]         ncols_ff;
   logic [NCOL_W-1:0]         ncols_in;
   logic signed [VAL_W-1:0]   ref_ff [MAX_COLS];
   logic signed [SC_W-1:0]    score_ff;
   logic                      sneg_ff;
   logic signed [RAT_W-1:0]   worst_ff;
   logic signed [RAT_W-1:0]   best_ff;
   logic                      found_ff;
   logic                      drop_ff;
   logic [RW-1:0]             best_row_ff;
   logic                      rsp_valid_ff;
   cgm_pkg::cgm_rsp_type      rsp_data_ff;

   logic [5:0][VAL_W-1:0]     in_vals;
   row_word_type              new_row;
   logic signed [VAL_W-1:0]   cur_c, cur_r;
   logic [THR_W-1:0]          cur_t;
   logic signed [DIFF_W-1:0]  diff, num;
   logic [DIFF_W-1:0]         diff_mag, num_mag;
   logic [DVS_W-1:0]          ref_mag;
   logic                      circ_hit, ref_zero;
   logic signed [SC_W-1:0]    score_direct, score_div;
   logic [SC_W-1:0]           score_mag, sdq;
   logic [RAT_W-1:0]          qsat;
   logic signed [RAT_W-1:0]   ratio;
   logic                      div_start;
   logic [DVD_W-1:0]          div_dvd;
   logic [DVS_W-1:0]          div_dvs;
   logic                      div_done;
   logic [DVD_W-1:0]          div_quo;
   logic [RW:0]               best_row_p1;

   assign in_vals = {req_data.val_5, req_data.val_4, req_data.val_3,
                     req_data.val_2, req_data.val_1, req_data.val_0};

   always_comb begin
      for (int j = 0; j < MAX_COLS; j++) begin
         new_row[j] = in_vals[j];
      end
      if (ncfg_ff == '0) begin
         ncols_in = NCOL_W'(1);
      end else if (ncfg_ff > NCOL_W'(MAX_COLS)) begin
         ncols_in = NCOL_W'(MAX_COLS);
      end else begin
         ncols_in = ncfg_ff;
      end
   end

   // Column scoring.
   always_comb begin
      cur_c    = $signed(rd_row_ff[col_ff]);
      cur_r    = ref_ff[col_ff];
      cur_t    = thr_ff[col_ff];
      diff     = DIFF_W'(cur_c) - DIFF_W'(cur_r);
      num      = cgm_pkg::DEG360 - diff;
      diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      num_mag  = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
      ref_mag  = cur_r[VAL_W-1] ? DVS_W'(-cur_r) : DVS_W'(cur_r);
      circ_hit = circ_ff[col_ff] && (diff > cgm_pkg::DEG180);
      ref_zero = (cur_r == '0);
      if (circ_hit) begin
         score_direct = num[DIFF_W-1] ? -cgm_pkg::SCORE_SAT : cgm_pkg::SCORE_SAT;
      end else begin
         score_direct = $signed(SC_W'(diff_mag));
      end
      sdq       = SC_W'(div_quo);
      score_div = sneg_ff ? -$signed(sdq) : $signed(sdq);
      score_mag = score_ff[SC_W-1] ? SC_W'(-score_ff) : SC_W'(score_ff);
      qsat      = (div_quo > cgm_pkg::RATIO_LIM) ? RAT_W'(cgm_pkg::RATIO_LIM)
                                                 : RAT_W'(div_quo);
      if (cur_t == '0) begin
         ratio = -cgm_pkg::RATIO_SAT;
      end else if (score_ff[SC_W-1]) begin
         ratio = -$signed(qsat);
      end else begin
         ratio = $signed(qsat);
      end
      div_start = cmd.sdiv_start || cmd.rdiv_start;
      if (cmd.rdiv_start) begin
         div_dvd = DVD_W'({score_mag, 16'b0});
         div_dvs = DVS_W'(cur_t);
      end else begin
         div_dvd = DVD_W'({num_mag, 16'b0});
         div_dvs = ref_mag;
      end
      best_row_p1 = {1'b0, best_row_ff} + 1'b1;
   end

   cgm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Memories.
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         cand_mem[rows_ff[RW-1:0]] <= new_row;
      end
      if (cmd.rd_row) begin
         rd_row_ff <= cand_mem[row_ff[RW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         live_mem[rows_ff[RW-1:0]] <= 1'b1;
      end else if (cmd.finish && found_ff) begin
         live_mem[best_row_ff] <= 1'b0;
      end
      if (cmd.rd_row) begin
         rd_live_ff <= live_mem[row_ff[RW-1:0]];
      end
   end

   // Working registers without reset.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff   <= '0;
         ncols_ff <= ncols_in;
         for (int j = 0; j < MAX_COLS; j++) begin
            ref_ff[j] <= $signed(in_vals[j]);
         end
      end else if (cmd.row_adv || cmd.row_end) begin
         row_ff <= row_ff + 1'b1;
      end
      if (cmd.col_zero) begin
         col_ff <= '0;
      end else if (cmd.col_adv) begin
         col_ff <= col_ff + 1'b1;
      end
      if (cmd.sdiv_start) begin
         sneg_ff <= num[DIFF_W-1] != cur_r[VAL_W-1];
      end
      if (cmd.score_direct) begin
         score_ff <= score_direct;
      end else if (cmd.score_div) begin
         score_ff <= score_div;
      end
      if (cmd.ratio_ld && ((col_ff == '0) || (ratio > worst_ff))) begin
         worst_ff <= ratio;
      end
      if (cmd.row_end && (!found_ff || (worst_ff < best_ff))) begin
         best_ff     <= worst_ff;
         best_row_ff <= row_ff[RW-1:0];
      end
      if (cmd.finish) begin
         if (drop_ff) begin
            rsp_data_ff.match_row <= '0;
            rsp_data_ff.status    <= cgm_pkg::ST_DROPPED;
         end else if (found_ff) begin
            rsp_data_ff.match_row <= OUT_W'(best_row_p1);
            rsp_data_ff.status    <= cgm_pkg::ST_MATCHED;
         end else begin
            rsp_data_ff.match_row <= '0;
            rsp_data_ff.status    <= cgm_pkg::ST_NONE;
         end
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < cgm_pkg::NUM_THR; j++) begin
            thr_ff[j] <= cgm_pkg::THR_RESET;
         end
         circ_ff      <= '0;
         ncfg_ff      <= cgm_pkg::COLS_RESET;
         rows_ff      <= '0;
         found_ff     <= 1'b0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index <= cgm_pkg::CSR_THRES_LAST) begin
               thr_ff[csr_index] <= csr_wdata;
            end else if (csr_index == cgm_pkg::CSR_CIRC_MASK) begin
               circ_ff <= csr_wdata[cgm_pkg::CIRC_W-1:0];
            end else if (csr_index == cgm_pkg::CSR_COLS_IN_USE) begin
               ncfg_ff <= csr_wdata[NCOL_W-1:0];
            end
         end
         if (cmd.clear) begin
            rows_ff <= '0;
         end else if (cmd.append) begin
            rows_ff <= rows_ff + 1'b1;
         end
         if (cmd.start || cmd.drop) begin
            found_ff <= 1'b0;
         end else if (cmd.row_end && (!found_ff || (worst_ff < best_ff))) begin
            found_ff <= 1'b1;
         end
         if (cmd.start) begin
            drop_ff <= 1'b0;
         end else if (cmd.drop) begin
            drop_ff <= 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      stat.full      = (rows_ff == (RW + 1)'(MAX_ROWS));
      stat.row_done  = (row_ff >= rows_ff);
      stat.live      = rd_live_ff;
      stat.circ_div  = circ_hit && !ref_zero;
      stat.below_thr = score_ff < $signed(SC_W'(cur_t));
      stat.thr_zero  = (cur_t == '0);
      stat.col_last  = (NCOL_W'(col_ff) + 1'b1) == ncols_ff;
      stat.div_done  = div_done;
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

FILE: sv/cgm_ctrl.sv
// Controller of the covariate matcher: walks rows and columns of a match
// and sequences the datapath. Depends on cgm_pkg.
module cgm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  cgm_pkg::cgm_stat_type stat,
   output cgm_pkg::cgm_cmd_type  cmd
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_ROW   = 10'b00_0000_0010,
      S_LIVE  = 10'b00_0000_0100,
      S_COL   = 10'b00_0000_1000,
      S_SDIV  = 10'b00_0001_0000,
      S_CHK   = 10'b00_0010_0000,
      S_RDIV  = 10'b00_0100_0000,
      S_CNEXT = 10'b00_1000_0000,
      S_FIN   = 10'b01_0000_0000,
      S_SPARE = 10'b10_0000_0000
   } cgm_state_type;

   cgm_state_type state_ff, state_in;
   logic          accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == cgm_pkg::REQ_CLEAR) begin
                  cmd.clear = 1'b1;
               end else if (req_kind == cgm_pkg::REQ_APPEND) begin
                  if (stat.full) begin
                     cmd.drop = 1'b1;
                     state_in = S_FIN;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end else if (req_kind == cgm_pkg::REQ_MATCH) begin
                  cmd.start = 1'b1;
                  state_in  = S_ROW;
               end
            end
         end
         S_ROW: begin
            if (stat.row_done) begin
               state_in = S_FIN;
            end else begin
               cmd.rd_row = 1'b1;
               state_in   = S_LIVE;
            end
         end
         S_LIVE: begin
            if (stat.live) begin
               cmd.col_zero = 1'b1;
               state_in     = S_COL;
            end else begin
               cmd.row_adv = 1'b1;
               state_in    = S_ROW;
            end
         end
         S_COL: begin
            if (stat.circ_div) begin
               cmd.sdiv_start = 1'b1;
               state_in       = S_SDIV;
            end else begin
               cmd.score_direct = 1'b1;
               state_in         = S_CHK;
            end
         end
         S_SDIV: begin
            if (stat.div_done) begin
               cmd.score_div = 1'b1;
               state_in      = S_CHK;
            end
         end
         S_CHK: begin
            if (!stat.below_thr) begin
               cmd.row_adv = 1'b1;
               state_in    = S_ROW;
            end else if (stat.thr_zero) begin
               cmd.ratio_ld = 1'b1;
               state_in     = S_CNEXT;
            end else begin
               cmd.rdiv_start = 1'b1;
               state_in       = S_RDIV;
            end
         end
         S_RDIV: begin
            if (stat.div_done) begin
               cmd.ratio_ld = 1'b1;
               state_in     = S_CNEXT;
            end
         end
         S_CNEXT: begin
            if (stat.col_last) begin
               cmd.row_end = 1'b1;
               state_in    = S_ROW;
            end else begin
               cmd.col_adv = 1'b1;
               state_in    = S_COL;
            end
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

FILE: sv/covariate_greedy_match.sv
// Clear and accepted append complete in the idle state; a dropped append answers
// from the finish state. A match walks R loaded rows and C compared columns:
// each column may need two divisions in the one shared bit-serial divider,
// and each row is one read of the candidate memory.
// One transaction is worked on at a time; a finished result waits in the output
// register while the next transaction is taken. Reset empties the table at once.
module covariate_greedy_match #(
   parameter int MAX_ROWS = cgm_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = cgm_pkg::DEF_MAX_COLS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [cgm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cgm_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cgm_pkg::cgm_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cgm_pkg::cgm_rsp_type            rsp_data
);
   cgm_pkg::cgm_cmd_type  cmd;
   cgm_pkg::cgm_stat_type stat;

   cgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_data.req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   cgm_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

FILE: sv/cgm_checker.sv
// Port-level checks of the covariate matcher, bound to the top level.
// Depends on cgm_pkg and covariate_greedy_match_defines.svh.
`include "covariate_greedy_match_defines.svh"

module cgm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input cgm_pkg::cgm_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input cgm_pkg::cgm_rsp_type rsp_data
);
   // A stalled result holds.
   `CGM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // A match reports a real row number.
   `CGM_ASSERT_NOW(a_match_row, rsp_valid && (rsp_data.status == cgm_pkg::ST_MATCHED), rsp_data.match_row != '0)
   // Any other outcome reports row zero.
   `CGM_ASSERT_NOW(a_nomatch_row, rsp_valid && (rsp_data.status != cgm_pkg::ST_MATCHED), rsp_data.match_row == '0)
   // A match transaction always keeps the block busy for the next cycle.
   `CGM_ASSERT_NEXT(a_match_busy, req_valid && !req_stall && (req_data.req_type == cgm_pkg::REQ_MATCH), req_stall)
endmodule

bind covariate_greedy_match cgm_checker u_cgm_checker (.*);
